// ===== rtl/adam_parameter_update_top_macros.svh =====
// ----------------------------------------------------------------------------
// Adam update engine - assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_TOP_MACROS_SVH
`define ADAM_PARAMETER_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define AP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/adam_pu_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam update engine - package
// Transaction types, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adam_pu_pkg;

  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABILIZER   = 2'd3;

  // Register reset values
  localparam logic [23:0] STEP_SIZE_RST    = 24'd16777;
  localparam logic [15:0] FIRST_DECAY_RST  = 16'd58982;
  localparam logic [15:0] SECOND_DECAY_RST = 16'd65470;
  localparam logic [31:0] STABILIZER_RST   = 32'd43;

  typedef struct packed {
    logic signed [31:0] gradient;
    logic [IDX_W-1:0]   param_index;
    logic               fresh_start;
    logic               end_of_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] update_value;
    logic [IDX_W-1:0]   update_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_READ,
    ST_PREP,
    ST_MIX,
    ST_FOLD,
    ST_ROOT,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/adam_pu_root.sv =====
// ----------------------------------------------------------------------------
// Adam update engine - serial square root
// Restoring integer root, one result bit per cycle, of a 64-bit radicand
// scaled by 4^(ITERS-32).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_pu_root #(
  parameter int ITERS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [63:0]      radicand,
  output logic             done,
  output logic [ITERS-1:0] root
);

  localparam int RW = ITERS + 2;
  localparam int CW = $clog2(ITERS + 1);

  logic [63:0]      x_r, x_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [ITERS-1:0] root_r, root_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;

  // One root bit per cycle; radicand pairs shift out of the top
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[RW-3:0], x_r[63:62]};
    trial    = {root_r, 2'b01};
    if (start) begin
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ITERS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ITERS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/adam_pu_div.sv =====
// ----------------------------------------------------------------------------
// Adam update engine - serial divider
// Restoring division of a 64-bit numerator, one quotient bit per cycle.
// The denominator must be nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_pu_div #(
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [63:0]      numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [63:0]      quot
);

  logic [63:0]      num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;

  // Numerator bits shift out the top, quotient bits shift in the bottom
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, num_r[63]};
    rem_dif  = rem_sh - {1'b0, den_r};
    if (start) begin
      num_nxt  = numer;
      rem_nxt  = '0;
      den_nxt  = denom;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_dif[DEN_W-1:0];
        num_nxt = {num_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        num_nxt = {num_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ===== rtl/adam_parameter_update_top.sv =====
// ----------------------------------------------------------------------------
// Adam update engine - top level
// Per-parameter moment update and bias-corrected Adam step, bit-serial.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying gradient, parameter index and flags.
//   out_* : valid/ready channel carrying the signed Q15.16 step and index.
//   cfg_* : write-only register port (step size, two decays, stabilizer);
//           write only while no transaction is in flight.
// Sequence: from input acceptance to result valid, the index wrap, the
//   read, the moment mix, the fold, the root of the second moment, the
//   division, the product and the saturate/load.
// Throughput: one transaction at a time; the serial 48-step root feeding the
//   64-step divider sets the pace. The step factor (root of 1-p2, division
//   by 1-p1) runs alongside on its own units.
// Reset: a clearing pass writes zero moments to all PARAM_COUNT entries;
//   in_ready stays low meanwhile.
// Stall: the result sits in an output register; a new transaction is
//   accepted while it waits, and the next result waits until it is taken.
// The gradient field is 32 bits; its low GRAD_WIDTH bits are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_parameter_update_top #(
  parameter int PARAM_COUNT = 1024,
  parameter int GRAD_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  adam_pu_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output adam_pu_pkg::out_item_t              out_data,
  input  logic                                cfg_we,
  input  logic [adam_pu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adam_pu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int IW = (AW > adam_pu_pkg::IDX_W) ? AW : adam_pu_pkg::IDX_W;
  localparam int GX = (GRAD_WIDTH > 32) ? GRAD_WIDTH : 32;

  // Configuration and bias-correction powers
  logic [23:0] step_size_r;
  logic [15:0] first_decay_r, second_decay_r;
  logic [31:0] stabilizer_r;
  logic [31:0] first_power_r, second_power_r;

  // Sequencer and item state
  adam_pu_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic signed [31:0]  g_r, g_nxt;
  logic [adam_pu_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                fresh_r, fresh_nxt;
  logic                eos_r, eos_nxt;
  logic [3:0]          kc_r, kc_nxt;
  logic [3:0]          bc_r, bc_nxt;
  logic [63:0]         gg_r, gg_nxt;
  logic signed [32:0]  dm_r, dm_nxt;
  logic signed [65:0]  dv_r, dv_nxt;
  logic signed [49:0]  acc_m_r, acc_m_nxt;
  logic signed [82:0]  acc_v_r, acc_v_nxt;
  logic                neg_r, neg_nxt;
  logic [31:0]         mag_r, mag_nxt;
  logic [2:0]          mc_r, mc_nxt;
  logic [1:0]          pk_r, pk_nxt;
  logic [63:0]         pp_r, pp_nxt;
  logic [127:0]        prod_r, prod_nxt;
  logic [31:0]         res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  adam_pu_pkg::out_item_t out_data_r, out_data_nxt;
  logic                adv_pow;

  // Step factor chain
  logic [55:0] sprod_r;
  logic        sprod_go_r;
  logic        step_rdy_r;

  // Moment memories
  logic signed [31:0] mem_m [PARAM_COUNT];
  logic [63:0]        mem_v [PARAM_COUNT];
  logic signed [31:0] m_rd_r;
  logic [63:0]        v_rd_r;
  logic [IW-1:0]      idx_wide;
  logic [AW-1:0]      mem_addr;
  logic [AW-1:0]      mem_waddr;
  logic               mem_we;
  logic signed [31:0] mem_wm;
  logic [63:0]        mem_wv;

  // Unit connections
  logic        root_s_done, root_d_done, div_s_done, div_m_done;
  logic        root_d_start, div_m_start, in_fire;
  logic [31:0] root_s_val;
  logic [47:0] root_d_val;
  logic [63:0] step_q, ratio_q;
  logic [32:0] one_m_p1, one_m_p2;
  logic [48:0] den_d;

  // Combinational helpers
  logic [GX-1:0]         g_zx;
  logic [GRAD_WIDTH-1:0] g_raw;
  logic signed [GX-1:0]  g_sx;
  logic [GX-32:0]        g_top;
  logic signed [31:0]    g_sat;
  logic [31:0]           g_abs;
  logic [26:0]           wrap_sub;
  logic signed [31:0]    m_old;
  logic [63:0]           v_old;
  logic signed [49:0]    m_full;
  logic [82:0]           v_full;
  logic signed [31:0]    m_new;
  logic [31:0]           a_half, b_half;
  logic [1:0]            sh_sel;
  logic [63:0]           mag64;
  logic [63:0]           limit64;
  logic [31:0]           mag_fin;

  assign in_ready = (state_r == adam_pu_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Gradient: low GRAD_WIDTH bits as two's complement, saturated to 32 bits
  always_comb begin
    g_zx  = GX'($unsigned(in_data.gradient));
    g_raw = g_zx[GRAD_WIDTH-1:0];
    g_sx  = GX'($signed(g_raw));
    g_top = g_sx[GX-1:31];
    if ((&g_top) || !(|g_top)) begin
      g_sat = g_sx[31:0];
    end else if (g_sx[GX-1]) begin
      g_sat = 32'sh8000_0000;
    end else begin
      g_sat = 32'sh7FFF_FFFF;
    end
  end

  assign g_abs    = g_r[31] ? 32'(-g_r) : g_r;
  assign idx_wide = IW'(idx_r);
  assign mem_addr = idx_wide[AW-1:0];
  assign wrap_sub = 27'(PARAM_COUNT) << kc_r;

  assign one_m_p1 = {1'b1, 32'd0} - {1'b0, first_power_r};
  assign one_m_p2 = {1'b1, 32'd0} - {1'b0, second_power_r};

  // Moment fold: add back g scaled by one and round
  assign m_old  = fresh_r ? 32'sd0 : m_rd_r;
  assign v_old  = fresh_r ? 64'd0 : v_rd_r;
  assign m_full = acc_m_r + (50'(g_r) <<< 16) + 50'sd32768;
  assign v_full = $unsigned(acc_v_r) + (83'(gg_r) << 16) + 83'd32768;
  assign m_new  = m_full[47:16];

  // Stabilized denominator, never zero
  always_comb begin
    den_d = 49'(root_d_val) + 49'(stabilizer_r);
    if (den_d == 49'd0) begin
      den_d = 49'd1;
    end
  end

  // Partial product selection
  assign a_half = mc_r[0] ? step_q[63:32] : step_q[31:0];
  assign b_half = mc_r[1] ? ratio_q[63:32] : ratio_q[31:0];
  assign sh_sel = {pk_r[0] & pk_r[1], pk_r[0] ^ pk_r[1]};

  // Saturation of the final magnitude
  always_comb begin
    mag64   = prod_r[94:31];
    limit64 = neg_r ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if ((|prod_r[127:95]) || (mag64 > limit64)) begin
      mag_fin = limit64[31:0];
    end else begin
      mag_fin = mag64[31:0];
    end
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    g_nxt         = g_r;
    idx_nxt       = idx_r;
    fresh_nxt     = fresh_r;
    eos_nxt       = eos_r;
    kc_nxt        = kc_r;
    bc_nxt        = bc_r;
    gg_nxt        = gg_r;
    dm_nxt        = dm_r;
    dv_nxt        = dv_r;
    acc_m_nxt     = acc_m_r;
    acc_v_nxt     = acc_v_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    mc_nxt        = mc_r;
    pk_nxt        = pk_r;
    pp_nxt        = pp_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = mem_addr;
    mem_wm        = m_new;
    mem_wv        = v_full[79:16];
    root_d_start  = 1'b0;
    div_m_start   = 1'b0;
    adv_pow       = 1'b0;

    // Output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      adam_pu_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wm    = 32'sd0;
        mem_wv    = 64'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(PARAM_COUNT - 1)) begin
          state_nxt = adam_pu_pkg::ST_IDLE;
        end
      end
      adam_pu_pkg::ST_IDLE: begin
        if (in_valid) begin
          g_nxt     = g_sat;
          idx_nxt   = in_data.param_index;
          fresh_nxt = in_data.fresh_start;
          eos_nxt   = in_data.end_of_step;
          kc_nxt    = 4'd9;
          state_nxt = adam_pu_pkg::ST_WRAP;
        end
      end
      // Index modulo PARAM_COUNT, one shifted subtract per cycle
      adam_pu_pkg::ST_WRAP: begin
        if ({17'd0, idx_r} >= wrap_sub) begin
          idx_nxt = idx_r - wrap_sub[adam_pu_pkg::IDX_W-1:0];
        end
        kc_nxt = kc_r - 1'b1;
        if (kc_r == 4'd0) begin
          state_nxt = adam_pu_pkg::ST_READ;
        end
      end
      adam_pu_pkg::ST_READ: begin
        gg_nxt    = g_abs * g_abs;
        state_nxt = adam_pu_pkg::ST_PREP;
      end
      adam_pu_pkg::ST_PREP: begin
        dm_nxt    = 33'(m_old) - 33'(g_r);
        dv_nxt    = $signed({2'b00, v_old}) - $signed({2'b00, gg_r});
        acc_m_nxt = '0;
        acc_v_nxt = '0;
        bc_nxt    = 4'd15;
        state_nxt = adam_pu_pkg::ST_MIX;
      end
      // Decay times difference, one decay bit per cycle from the top
      adam_pu_pkg::ST_MIX: begin
        acc_m_nxt = (acc_m_r <<< 1) + (first_decay_r[bc_r] ? 50'(dm_r) : 50'sd0);
        acc_v_nxt = (acc_v_r <<< 1) + (second_decay_r[bc_r] ? 83'(dv_r) : 83'sd0);
        bc_nxt    = bc_r - 1'b1;
        if (bc_r == 4'd0) begin
          state_nxt = adam_pu_pkg::ST_FOLD;
        end
      end
      adam_pu_pkg::ST_FOLD: begin
        mem_we       = 1'b1;
        root_d_start = 1'b1;
        neg_nxt      = m_new[31];
        mag_nxt      = m_new[31] ? 32'(-m_new) : m_new;
        state_nxt    = adam_pu_pkg::ST_ROOT;
      end
      adam_pu_pkg::ST_ROOT: begin
        if (root_d_done) begin
          div_m_start = 1'b1;
          state_nxt   = adam_pu_pkg::ST_DIV;
        end
      end
      adam_pu_pkg::ST_DIV: begin
        if (div_m_done) begin
          mc_nxt    = 3'd0;
          state_nxt = adam_pu_pkg::ST_MUL;
        end
      end
      // Step times ratio from four 32x32 partial products
      adam_pu_pkg::ST_MUL: begin
        if (step_rdy_r || (mc_r != 3'd0)) begin
          mc_nxt = mc_r + 1'b1;
          pp_nxt = a_half * b_half;
          pk_nxt = mc_r[1:0];
          if (mc_r == 3'd0) begin
            prod_nxt = '0;
          end else begin
            prod_nxt = prod_r + (128'(pp_r) << {sh_sel, 5'd0});
          end
          if (mc_r == 3'd4) begin
            state_nxt = adam_pu_pkg::ST_SAT;
          end
        end
      end
      adam_pu_pkg::ST_SAT: begin
        res_nxt   = neg_r ? 32'(-mag_fin) : mag_fin;
        state_nxt = adam_pu_pkg::ST_DONE;
      end
      adam_pu_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.update_value = res_r;
          out_data_nxt.update_index = idx_r;
          adv_pow                   = eos_r;
          state_nxt                 = adam_pu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = adam_pu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adam_pu_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    g_r        <= g_nxt;
    idx_r      <= idx_nxt;
    fresh_r    <= fresh_nxt;
    eos_r      <= eos_nxt;
    kc_r       <= kc_nxt;
    bc_r       <= bc_nxt;
    gg_r       <= gg_nxt;
    dm_r       <= dm_nxt;
    dv_r       <= dv_nxt;
    acc_m_r    <= acc_m_nxt;
    acc_v_r    <= acc_v_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    mc_r       <= mc_nxt;
    pk_r       <= pk_nxt;
    pp_r       <= pp_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Moment memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_m[mem_waddr] <= mem_wm;
      mem_v[mem_waddr] <= mem_wv;
    end
    m_rd_r <= mem_m[mem_addr];
    v_rd_r <= mem_v[mem_addr];
  end

  // Registers and bias-correction powers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r    <= adam_pu_pkg::STEP_SIZE_RST;
      first_decay_r  <= adam_pu_pkg::FIRST_DECAY_RST;
      second_decay_r <= adam_pu_pkg::SECOND_DECAY_RST;
      stabilizer_r   <= adam_pu_pkg::STABILIZER_RST;
      first_power_r  <= {adam_pu_pkg::FIRST_DECAY_RST, 16'd0};
      second_power_r <= {adam_pu_pkg::SECOND_DECAY_RST, 16'd0};
    end else if (cfg_we) begin
      case (cfg_index)
        adam_pu_pkg::REG_STEP_SIZE: begin
          step_size_r <= cfg_data[23:0];
        end
        adam_pu_pkg::REG_FIRST_DECAY: begin
          first_decay_r <= cfg_data[15:0];
          first_power_r <= {cfg_data[15:0], 16'd0};
        end
        adam_pu_pkg::REG_SECOND_DECAY: begin
          second_decay_r <= cfg_data[15:0];
          second_power_r <= {cfg_data[15:0], 16'd0};
        end
        adam_pu_pkg::REG_STABILIZER: begin
          stabilizer_r <= cfg_data;
        end
        default: begin
          stabilizer_r <= stabilizer_r;
        end
      endcase
    end else if (adv_pow) begin
      // p = round(p * decay / 2^16)
      first_power_r  <= 32'((49'(first_power_r) * 49'(first_decay_r) + 49'd32768) >> 16);
      second_power_r <= 32'((49'(second_power_r) * 49'(second_decay_r) + 49'd32768) >> 16);
    end
  end

  // Step factor chain: root(1-p2), times alpha, divided by 1-p1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprod_go_r <= 1'b0;
      step_rdy_r <= 1'b0;
    end else begin
      sprod_go_r <= root_s_done;
      if (in_fire) begin
        step_rdy_r <= 1'b0;
      end else if (div_s_done) begin
        step_rdy_r <= 1'b1;
      end
    end
    if (root_s_done) begin
      sprod_r <= step_size_r * root_s_val;
    end
  end

  adam_pu_root #(
    .ITERS(32)
  ) u_root_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .radicand (64'(one_m_p2) << 30),
    .done     (root_s_done),
    .root     (root_s_val)
  );

  adam_pu_div #(
    .DEN_W(33)
  ) u_div_s (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sprod_go_r),
    .numer ({sprod_r, 8'd0}),
    .denom (one_m_p1),
    .done  (div_s_done),
    .quot  (step_q)
  );

  adam_pu_root #(
    .ITERS(48)
  ) u_root_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_d_start),
    .radicand (v_full[79:16]),
    .done     (root_d_done),
    .root     (root_d_val)
  );

  adam_pu_div #(
    .DEN_W(49)
  ) u_div_m (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_m_start),
    .numer ({mag_r, 32'd0}),
    .denom (den_d),
    .done  (div_m_done),
    .quot  (ratio_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/adam_pu_checker.sv =====
// ----------------------------------------------------------------------------
// Adam update engine - port checker
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adam_parameter_update_top_macros.svh"

module adam_pu_checker #(
  parameter int PARAM_COUNT = 1024
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input adam_pu_pkg::out_item_t out_data
);

  // A stalled result stays offered
  `AP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `AP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result changed")

  // One transaction at a time: busy right after acceptance
  `AP_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "input taken while busy")

  // Reported index is always wrapped into the store
  `AP_ASSERT_NOW(a_idx_range, out_valid, 32'(out_data.update_index) < PARAM_COUNT, "index not wrapped")

endmodule

bind adam_parameter_update_top adam_pu_checker #(
  .PARAM_COUNT(PARAM_COUNT)
) u_adam_pu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/adam_parameter_update_top_tb.sv =====
// ----------------------------------------------------------------------------
// Adam update engine - testbench
// Drives gradient transactions through the valid/ready input channel, writes
// the four step registers between phases, and checks every result against a
// cycle-free predictor of the moment update and the bias-corrected step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_parameter_update_top_tb;

  localparam int PCOUNT   = 1024;
  localparam int DRAIN    = 200;    // cycles after the last result
  localparam int WD_LIMIT = 20000;  // cycles without any transaction
  localparam logic [63:0] ONE32 = 64'h1_0000_0000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  adam_pu_pkg::in_item_t  in_data;
  adam_pu_pkg::out_item_t out_data;
  logic cfg_we;
  logic [adam_pu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [adam_pu_pkg::CFG_DATA_W-1:0] cfg_data;

  adam_parameter_update_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor state: moment stores, powers, register copies
  logic signed [31:0] mom1 [PCOUNT];
  logic [63:0]        mom2 [PCOUNT];
  logic [63:0] pow1, pow2, alpha, beta1, beta2, eps;

  adam_pu_pkg::out_item_t steps_due[$];
  int errors = 0;
  int snd_idle = 0, rcv_idle = 0;

  typedef struct {
    bit                                is_cfg;
    logic [adam_pu_pkg::CFG_IDX_W-1:0] reg_sel;
    logic [31:0]                       val;
    adam_pu_pkg::in_item_t             item;
    bit                                typed;
    logic signed [31:0]                want;
  } row_t;
  row_t plan[$];

  // Table rows: one input transaction, or one register write
  function automatic void add_item(adam_pu_pkg::in_item_t it, bit typed,
                                   logic signed [31:0] want);
    row_t r;
    r.is_cfg  = 1'b0;
    r.reg_sel = adam_pu_pkg::REG_STEP_SIZE;
    r.val     = '0;
    r.item    = it;
    r.typed   = typed;
    r.want    = want;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_cfg(logic [adam_pu_pkg::CFG_IDX_W-1:0] sel,
                                  logic [31:0] val);
    row_t r;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.val     = val;
    r.item    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan.insert(plan.size(), r);
  endfunction

  // Floor square root of x * 4^extra, two bits per pass
  function automatic logic [63:0] isqrt(logic [63:0] x, int extra);
    logic [63:0] rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 0; i < 32 + extra; i++) begin
      pair = (i < 32) ? ((x >> (62 - 2 * i)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Moment update and bias-corrected step for one gradient
  function automatic adam_pu_pkg::out_item_t adam_step(adam_pu_pkg::in_item_t it);
    logic signed [63:0] g, mold, kk, x;
    logic signed [31:0] mnew;
    logic [63:0] vold, vnew, gg, t2, whole, part, s, stp, mag, d, r, limit;
    logic [127:0] prod;
    logic [9:0] idx;
    bit neg;
    adam_pu_pkg::out_item_t res;
    g = 64'($signed(it.gradient));
    idx = 10'(it.param_index % PCOUNT);
    mold = it.fresh_start ? 64'sd0 : 64'($signed(mom1[idx]));
    vold = it.fresh_start ? 64'd0 : mom2[idx];
    kk = $signed(beta1);
    x = kk * mold + (64'sd65536 - kk) * g;
    mnew = 32'((x + 64'sd32768) >>> 16);
    gg = g * g;
    t2 = 64'd65536 - beta2;
    whole = beta2 * (vold >> 16) + t2 * (gg >> 16);
    part = beta2 * (vold & 64'hFFFF) + t2 * (gg & 64'hFFFF) + 64'd32768;
    vnew = whole + (part >> 16);
    mom1[idx] = mnew;
    mom2[idx] = vnew;
    s = isqrt((ONE32 - pow2) << 30, 0);
    stp = ((alpha * s) << 8) / (ONE32 - pow1);
    neg = mnew < 0;
    mag = neg ? 64'(-64'($signed(mnew))) : 64'($signed(mnew));
    d = isqrt(vnew, 16) + eps;
    if (d == 0) d = 1;
    r = (mag << 32) / d;
    prod = {64'd0, stp} * {64'd0, r};
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (prod[127:95] != 0) begin
      mag = limit;
    end else begin
      mag = prod[94:31];
      if (mag > limit) mag = limit;
    end
    res.update_value = neg ? -mag[31:0] : mag[31:0];
    res.update_index = idx;
    if (it.end_of_step) begin
      pow1 = ((pow1 * beta1) + 64'd32768) >> 16;
      pow2 = ((pow2 * beta2) + 64'd32768) >> 16;
    end
    return res;
  endfunction

  // Register write, only once the engine has drained
  task automatic write_reg(logic [adam_pu_pkg::CFG_IDX_W-1:0] sel, logic [31:0] val);
    while (steps_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    case (sel)
      adam_pu_pkg::REG_STEP_SIZE:    alpha = val[23:0];
      adam_pu_pkg::REG_FIRST_DECAY: begin
        beta1 = val[15:0];
        pow1 = {32'd0, val[15:0], 16'd0};
      end
      adam_pu_pkg::REG_SECOND_DECAY: begin
        beta2 = val[15:0];
        pow2 = {32'd0, val[15:0], 16'd0};
      end
      default:          eps = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One input transaction: optional idle gap, then hold until accepted
  task automatic send(adam_pu_pkg::in_item_t it, bit typed, logic signed [31:0] want);
    adam_pu_pkg::out_item_t res;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    res = adam_step(it);
    if (typed) res.update_value = want;
    steps_due.insert(steps_due.size(), res);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic adam_pu_pkg::in_item_t rand_item();
    adam_pu_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) it.gradient = $signed($urandom_range(262143)) - 131072;
    else if (pick < 85) it.gradient = $signed($urandom_range(33554431)) - 16777216;
    else it.gradient = $urandom;
    it.param_index = ($urandom_range(9) < 7) ? 10'($urandom_range(15))
                                             : 10'($urandom_range(1023));
    it.fresh_start = ($urandom_range(11) == 0);
    it.end_of_step = ($urandom_range(7) == 0);
    return it;
  endfunction

  // Result side: random back-pressure, compare in order
  always @(negedge clk) out_ready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (steps_due.size() == 0) begin
        $error("unexpected result: value %0d index %0d",
               out_data.update_value, out_data.update_index);
        errors++;
      end else begin
        if (out_data.update_value !== steps_due[0].update_value) begin
          $error("update_value: expected %0d, got %0d",
                 steps_due[0].update_value, out_data.update_value);
          errors++;
        end
        if (out_data.update_index !== steps_due[0].update_index) begin
          $error("update_index: expected %0d, got %0d",
                 steps_due[0].update_index, out_data.update_index);
          errors++;
        end
        void'(steps_due.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    adam_pu_pkg::in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = adam_pu_pkg::REG_STEP_SIZE;
    cfg_data = '0;
    for (int i = 0; i < PCOUNT; i++) begin
      mom1[i] = '0;
      mom2[i] = '0;
    end
    alpha = 64'(adam_pu_pkg::STEP_SIZE_RST);
    beta1 = 64'(adam_pu_pkg::FIRST_DECAY_RST);
    beta2 = 64'(adam_pu_pkg::SECOND_DECAY_RST);
    eps = 64'(adam_pu_pkg::STABILIZER_RST);
    pow1 = {32'd0, adam_pu_pkg::FIRST_DECAY_RST, 16'd0};
    pow2 = {32'd0, adam_pu_pkg::SECOND_DECAY_RST, 16'd0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero gradients give a zero step, extremes, stabilizer of zero
    add_item('{32'sd0, 10'd0, 1'b1, 1'b0}, 1, 32'sd0);
    add_item('{32'sd0, 10'd7, 1'b0, 1'b0}, 1, 32'sd0);
    add_item('{32'h7FFF_FFFF, 10'd1023, 1'b1, 1'b0}, 0, 0);
    add_item('{32'h8000_0000, 10'd1, 1'b1, 1'b0}, 0, 0);
    add_item('{32'sd1, 10'd2, 1'b0, 1'b0}, 0, 0);
    add_item('{-32'sd1, 10'd2, 1'b0, 1'b1}, 0, 0);
    add_item('{32'sh10000, 10'd3, 1'b0, 1'b1}, 0, 0);
    add_item('{32'h8000_0000, 10'd1, 1'b0, 1'b0}, 0, 0);
    add_item('{32'h7FFF_FFFF, 10'd1023, 1'b0, 1'b1}, 0, 0);
    add_item('{-32'sh30000, 10'd3, 1'b1, 1'b0}, 0, 0);
    add_cfg(adam_pu_pkg::REG_STABILIZER, 32'd0);
    add_item('{32'sd0, 10'd5, 1'b1, 1'b0}, 1, 32'sd0);
    add_item('{-32'sd2, 10'd6, 1'b1, 1'b0}, 0, 0);
    add_item('{32'sh100, 10'd6, 1'b0, 1'b1}, 0, 0);
    add_cfg(adam_pu_pkg::REG_STEP_SIZE, 32'hFF_FFFF);
    add_item('{32'sh7FFF_0000, 10'd8, 1'b1, 1'b0}, 0, 0);
    add_cfg(adam_pu_pkg::REG_FIRST_DECAY, 32'd0);
    add_cfg(adam_pu_pkg::REG_SECOND_DECAY, 32'd0);
    add_item('{32'sh12345, 10'd9, 1'b0, 1'b1}, 0, 0);
    add_item('{-32'sh12345, 10'd9, 1'b0, 1'b0}, 0, 0);
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].val);
      else send(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Random phases, each under its own register setting; the idle mix changes every two phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(adam_pu_pkg::REG_STEP_SIZE, 32'hFF_FFFF);
          write_reg(adam_pu_pkg::REG_FIRST_DECAY, 32'd1);
          write_reg(adam_pu_pkg::REG_SECOND_DECAY, 32'd1);
          write_reg(adam_pu_pkg::REG_STABILIZER, 32'd1);
        end
        1: begin
          write_reg(adam_pu_pkg::REG_STEP_SIZE, 32'd1);
          write_reg(adam_pu_pkg::REG_FIRST_DECAY, 32'hFFFF);
          write_reg(adam_pu_pkg::REG_SECOND_DECAY, 32'hFFFF);
          write_reg(adam_pu_pkg::REG_STABILIZER, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(adam_pu_pkg::REG_STEP_SIZE, 32'(adam_pu_pkg::STEP_SIZE_RST));
          write_reg(adam_pu_pkg::REG_FIRST_DECAY, 32'(adam_pu_pkg::FIRST_DECAY_RST));
          write_reg(adam_pu_pkg::REG_SECOND_DECAY, 32'(adam_pu_pkg::SECOND_DECAY_RST));
          write_reg(adam_pu_pkg::REG_STABILIZER, adam_pu_pkg::STABILIZER_RST);
        end
        default: begin
          write_reg(adam_pu_pkg::REG_STEP_SIZE, $urandom_range(24'hFF_FFFF, 1));
          write_reg(adam_pu_pkg::REG_FIRST_DECAY, $urandom_range(16'hFFFF, 1));
          write_reg(adam_pu_pkg::REG_SECOND_DECAY, $urandom_range(16'hFFFF, 1));
          write_reg(adam_pu_pkg::REG_STABILIZER, $urandom_range(4096, 1));
        end
      endcase
      snd_idle = (ph < 2) ? 11 : (ph < 4) ? 47 : 0;
      rcv_idle = (ph < 2) ? 47 : (ph < 4) ? 11 : 0;
      for (int n = 0; n < 215; n++) begin
        it = rand_item();
        send(it, 0, 0);
      end
    end

    while (steps_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/adam_pu_pkg.sv
rtl/adam_pu_root.sv
rtl/adam_pu_div.sv
rtl/adam_parameter_update_top.sv
rtl/adam_pu_checker.sv
verif/adam_parameter_update_top_tb.sv
